### hdl/tcs_pkg.sv
// types and codes shared by the tcp connection state table
// no dependencies
package tcs_pkg;

    localparam logic [1:0] OP_SET = 2'd0;
    localparam logic [1:0] OP_GET = 2'd1;
    localparam logic [1:0] OP_DEL = 2'd2;

    localparam logic [1:0] STATUS_DONE      = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STATUS_FULL      = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] src_addr;
        logic [15:0] src_port;
        logic [31:0] dst_addr;
        logic [15:0] dst_port;
        logic [3:0]  new_state;
    } tcs_in_t;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] found_state;
    } tcs_out_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] src_addr;
        logic [15:0] src_port;
        logic [31:0] dst_addr;
        logic [15:0] dst_port;
        logic [3:0]  state;
    } tcs_slot_t;

    localparam int SLOT_W = $bits(tcs_slot_t);

endpackage

### hdl/tcs_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module tcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hdl/tcp_connection_state_table.sv
// tcp connection state table: set, get and delete of per-connection state
// order of work: hash sum, bucket remainder, a read and a compare per slot, then the update
// a new beat is taken only once the last one is done, as the one ram read port visits the
// slots one at a time; a stalled result holds the next beat in its update state
// reset: a clearing pass invalidates every slot before input is taken
// depends on tcs_pkg and tcs_ram
module tcp_connection_state_table #(
    parameter int BUCKETS = 256,
    parameter int WAYS    = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  tcs_pkg::tcs_in_t in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output tcs_pkg::tcs_out_t out_data,
    input  logic             cfg_we,
    input  logic [3:0]       cfg_data
);

    localparam int DEPTH = BUCKETS * WAYS;
    localparam int AW    = $clog2(DEPTH);
    localparam int BW    = $clog2(BUCKETS);
    localparam int RW    = BW + 1;
    localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam logic [RW-1:0] BUCKETS_R = RW'(BUCKETS);
    localparam logic [WW-1:0] LAST_WAY  = WW'(WAYS - 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [AW-1:0] WAYS_A    = AW'(WAYS);
    localparam logic [31:0]   RECIP     = 32'((64'd1 << 32) / 64'(BUCKETS));
    localparam logic [31:0]   BUCKETS_W = 32'(BUCKETS);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SUM   = 3'd2;
    localparam logic [2:0] ST_MOD   = 3'd3;
    localparam logic [2:0] ST_READ  = 3'd4;
    localparam logic [2:0] ST_CMP   = 3'd5;
    localparam logic [2:0] ST_ACT   = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [AW-1:0]     clr_addr_reg, clr_addr_next;
    tcs_pkg::tcs_in_t  key_reg, key_next;
    logic [31:0]       sum_reg, sum_next;
    logic [RW-1:0]     rem_reg, rem_next;
    logic [1:0]        step_reg, step_next;
    logic [63:0]       prod_reg, prod_next;
    logic [AW-1:0]     base_reg, base_next;
    logic [WW-1:0]     way_reg, way_next;
    logic              hit_reg, hit_next;
    logic [AW-1:0]     hit_addr_reg, hit_addr_next;
    logic [3:0]        hit_state_reg, hit_state_next;
    logic              free_reg, free_next;
    logic [AW-1:0]     free_addr_reg, free_addr_next;
    logic              out_valid_reg, out_valid_next;
    tcs_pkg::tcs_out_t out_data_reg, out_data_next;
    logic [3:0]        closed_reg;

    logic                      ram_we;
    logic [AW-1:0]             ram_waddr;
    tcs_pkg::tcs_slot_t        ram_wslot;
    logic [AW-1:0]             ram_raddr;
    logic [tcs_pkg::SLOT_W-1:0] ram_rdata;
    tcs_pkg::tcs_slot_t        rd_slot;
    logic [31:0]               mul_a;
    logic [31:0]               mul_b;
    logic [63:0]               mul_p;
    logic                      key_match;
    logic                      in_take;

    tcs_ram #(
        .WIDTH(tcs_pkg::SLOT_W),
        .DEPTH(DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wslot),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_slot   = tcs_pkg::tcs_slot_t'(ram_rdata);
    assign ram_raddr = base_reg + AW'(way_reg);
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign mul_p     = 64'(mul_a) * 64'(mul_b);
    assign key_match = rd_slot.valid
                       && rd_slot.src_addr == key_reg.src_addr
                       && rd_slot.src_port == key_reg.src_port
                       && rd_slot.dst_addr == key_reg.dst_addr
                       && rd_slot.dst_port == key_reg.dst_port;

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        key_next       = key_reg;
        sum_next       = sum_reg;
        rem_next       = rem_reg;
        step_next      = step_reg;
        prod_next      = prod_reg;
        base_next      = base_reg;
        way_next       = way_reg;
        hit_next       = hit_reg;
        hit_addr_next  = hit_addr_reg;
        hit_state_next = hit_state_reg;
        free_next      = free_reg;
        free_addr_next = free_addr_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        mul_a          = '0;
        mul_b          = '0;
        ram_we         = 1'b0;
        ram_waddr      = clr_addr_reg;
        ram_wslot      = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we = 1'b1;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_take)
                begin
                    key_next   = in_data;
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                sum_next = key_reg.src_addr + key_reg.dst_addr
                           + 32'(key_reg.src_port) + 32'(key_reg.dst_port);
                step_next  = '0;
                state_next = ST_MOD;
            end
            ST_MOD:
            begin
                step_next = step_reg + 2'd1;
                case (step_reg)
                    2'd0:
                    begin
                        // quotient estimate, low by at most one
                        mul_a     = sum_reg;
                        mul_b     = RECIP;
                        prod_next = mul_p;
                    end
                    2'd1:
                    begin
                        mul_a     = prod_reg[63:32];
                        mul_b     = BUCKETS_W;
                        prod_next = mul_p;
                    end
                    2'd2:
                    begin
                        rem_next = RW'(sum_reg - prod_reg[31:0]);
                    end
                    default:
                    begin
                        rem_next   = (rem_reg >= BUCKETS_R) ? rem_reg - BUCKETS_R : rem_reg;
                        base_next  = AW'(rem_next[BW-1:0]) * WAYS_A;
                        way_next   = '0;
                        hit_next   = 1'b0;
                        free_next  = 1'b0;
                        state_next = ST_READ;
                    end
                endcase
            end
            ST_READ:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (!hit_reg && key_match)
                begin
                    hit_next       = 1'b1;
                    hit_addr_next  = ram_raddr;
                    hit_state_next = rd_slot.state;
                end
                if (!free_reg && !rd_slot.valid)
                begin
                    free_next      = 1'b1;
                    free_addr_next = ram_raddr;
                end
                if (way_reg == LAST_WAY)
                begin
                    state_next = ST_ACT;
                end
                else
                begin
                    way_next   = way_reg + WW'(1);
                    state_next = ST_READ;
                end
            end
            ST_ACT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_data_next.status      = tcs_pkg::STATUS_DONE;
                    out_data_next.found_state = 4'd0;
                    ram_wslot.valid    = 1'b1;
                    ram_wslot.src_addr = key_reg.src_addr;
                    ram_wslot.src_port = key_reg.src_port;
                    ram_wslot.dst_addr = key_reg.dst_addr;
                    ram_wslot.dst_port = key_reg.dst_port;
                    ram_wslot.state    = key_reg.new_state;
                    ram_waddr          = hit_reg ? hit_addr_reg : free_addr_reg;
                    case (key_reg.operation)
                        tcs_pkg::OP_SET:
                        begin
                            if (hit_reg || free_reg)
                            begin
                                ram_we = 1'b1;
                            end
                            else
                            begin
                                out_data_next.status = tcs_pkg::STATUS_FULL;
                            end
                        end
                        tcs_pkg::OP_GET:
                        begin
                            if (hit_reg)
                            begin
                                out_data_next.found_state = hit_state_reg;
                            end
                            else
                            begin
                                out_data_next.status      = tcs_pkg::STATUS_NOT_FOUND;
                                out_data_next.found_state = closed_reg;
                            end
                        end
                        tcs_pkg::OP_DEL:
                        begin
                            ram_wslot.valid = 1'b0;
                            if (hit_reg)
                            begin
                                ram_we = 1'b1;
                            end
                            else
                            begin
                                out_data_next.status = tcs_pkg::STATUS_NOT_FOUND;
                            end
                        end
                        default:
                        begin
                            out_data_next.status = tcs_pkg::STATUS_DONE;
                        end
                    endcase
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
            closed_reg    <= 4'd0;
            step_reg      <= '0;
            way_reg       <= '0;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
            way_reg       <= way_next;
            hit_reg       <= hit_next;
            free_reg      <= free_next;
            if (cfg_we)
            begin
                closed_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        sum_reg       <= sum_next;
        rem_reg       <= rem_next;
        prod_reg      <= prod_next;
        base_reg      <= base_next;
        hit_addr_reg  <= hit_addr_next;
        hit_state_reg <= hit_state_next;
        free_addr_reg <= free_addr_next;
        out_data_reg  <= out_data_next;
    end

    a_no_result_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> !out_valid_reg)
        else $error("result beat during clearing pass");

    a_write_only_clear_or_update: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_CLEAR || state_reg == ST_ACT))
        else $error("slot write outside clear or update");

    a_remainder_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_READ |-> rem_reg < BUCKETS_R)
        else $error("bucket remainder out of range");

    a_accept_starts_hash: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == ST_SUM)
        else $error("accepted beat did not start hashing");

    a_result_held_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> out_valid_reg && $stable(out_data_reg))
        else $error("stalled result beat changed");

endmodule
